### sv/bad_pkg.sv
// Package with the constants, codes and reset table of the bus address decoder.
package bad_pkg;

    localparam int PALETTE_WORDS = 256;
    localparam int PAL_BYTES     = 2 * PALETTE_WORDS;
    localparam int PAL_ROWS      = PALETTE_WORDS / 2;
    localparam int ROW_W         = $clog2(PAL_ROWS);
    localparam int WIDX_W        = $clog2(PALETTE_WORDS);
    localparam int OFF_W         = 10;

    localparam logic [23:0] GPAL_BASE  = 24'hE82000;
    localparam logic [23:0] GPAL_END   = 24'hE82200;
    localparam logic [23:0] TPAL_END   = 24'hE82400;
    localparam logic [23:0] PRIO_ADDR  = 24'hE82500;
    localparam logic [23:0] PCG_BASE   = 24'hEB8000;
    localparam logic [23:0] PCG_END    = 24'hEBC000;
    localparam logic [23:0] GPAGE_BASE = 24'hD00000;
    localparam logic [23:0] GPAGE_END  = 24'hD80000;
    localparam logic [23:0] SPR_BASE   = 24'hEB0000;
    localparam logic [23:0] SPR_END    = 24'hEB0400;
    localparam logic [23:0] IO_BASE    = 24'hC00000;

    localparam logic [23:0] RAM_LOW_RESET  = 24'h000000;
    localparam logic [23:0] RAM_HIGH_RESET = 24'hC00000;

    localparam logic [2:0] T_RAM   = 3'd0;
    localparam logic [2:0] T_IGN   = 3'd1;
    localparam logic [2:0] T_PAL   = 3'd2;
    localparam logic [2:0] T_GFX   = 3'd3;
    localparam logic [2:0] T_SPR   = 3'd4;
    localparam logic [2:0] T_FAULT = 3'd5;

    localparam logic [1:0] FC_NONE  = 2'd0;
    localparam logic [1:0] FC_IO    = 2'd1;
    localparam logic [1:0] FC_INVAL = 2'd2;
    localparam logic [1:0] FC_SIZE  = 2'd3;

    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_WORD = 2'd1;
    localparam logic [1:0] SZ_LONG = 2'd2;
    localparam logic [1:0] SZ_BAD  = 2'd3;

    localparam logic CFG_RAM_LOW  = 1'b0;
    localparam logic CFG_RAM_HIGH = 1'b1;

    function automatic logic [15:0] pal_reset_word(input logic [OFF_W-2:0] w);
        logic [15:0] v;
        case (w)
            9'd0:    v = 16'h0000;
            9'd1:    v = 16'h5294;
            9'd2:    v = 16'h0020;
            9'd3:    v = 16'h003E;
            9'd4:    v = 16'h0400;
            9'd5:    v = 16'h07C0;
            9'd6:    v = 16'h0420;
            9'd7:    v = 16'h07FE;
            9'd8:    v = 16'h0800;
            9'd9:    v = 16'hF800;
            9'd10:   v = 16'h8020;
            9'd11:   v = 16'hF83E;
            9'd12:   v = 16'h8400;
            9'd13:   v = 16'hFFC0;
            9'd14:   v = 16'hAD6A;
            9'd15:   v = 16'hFFFF;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] pal_reset_byte(input logic [OFF_W-1:0] b);
        logic [15:0] w;
        w = pal_reset_word(b[OFF_W-1:1]);
        return b[0] ? w[7:0] : w[15:8];
    endfunction

endpackage

### sv/bus_address_decoder_with_palette_top.sv
// Top level of the bus address decoder with its byte-banked graphic palette store.
// A result passes the decode stage register and then the output register. One access
// beat can be accepted every cycle unless the output stalls; the palette is four byte
// banks, each with one synchronous read and one write port, so any palette access
// fits in one pass. Reset restores the RAM window bounds and clears the per-word
// valid bits, so the palette reads its fixed colors at once; there is no clearing pass.
module bus_address_decoder_with_palette_top
    import bad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    input  logic [23:0] address,
    input  logic [1:0]  access_size,
    input  logic [31:0] write_data,
    input  logic        supervisor,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  target,
    output logic [1:0]  fault_code,
    output logic [23:0] index,
    output logic [31:0] data
);

    logic [23:0] ram_low_reg;
    logic [23:0] ram_high_reg;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        out_valid_reg;
    logic        in_fire;
    logic        s1_move;

    logic [2:0]  dec_tgt;
    logic [1:0]  dec_fc;
    logic [23:0] dec_idx;
    logic [31:0] dec_data;
    logic        dec_pal_rd;
    logic        dec_pal_wr;
    logic [23:0] gpage_off;
    logic [23:0] spr_off;
    logic [23:0] gpal_off;
    logic [OFF_W-1:0] off;
    logic [31:0] dmask;

    logic [ROW_W-1:0] wr_row;
    logic [WIDX_W-1:0] wr_widx;
    logic [3:0]  bank_we;

    logic [OFF_W-1:0] rd_byte_addr [4];
    logic [3:0]  rd_inr;

    logic [PALETTE_WORDS-1:0] vld_reg;

    logic [2:0]  s1_tgt_reg;
    logic [1:0]  s1_fc_reg;
    logic [23:0] s1_idx_reg;
    logic [31:0] s1_data_reg;
    logic        s1_pal_rd_reg;
    logic [1:0]  s1_sz_reg;
    logic [1:0]  s1_off_lo_reg;
    logic [7:0]  s1_mem_reg [4];
    logic [3:0]  s1_inr_reg;
    logic [3:0]  s1_vld_reg;
    logic [7:0]  s1_rst_reg [4];

    logic [7:0]  bank_byte [4];
    logic [7:0]  pos_byte [4];
    logic [31:0] rd_word;

    logic [2:0]  out_tgt_reg;
    logic [1:0]  out_fc_reg;
    logic [23:0] out_idx_reg;
    logic [31:0] out_data_reg;

    assign cfg_ready = 1'b1;
    assign s1_move   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || s1_move;
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_low_reg  <= RAM_LOW_RESET;
            ram_high_reg <= RAM_HIGH_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RAM_LOW:  ram_low_reg  <= cfg_data;
                CFG_RAM_HIGH: ram_high_reg <= cfg_data;
                default:      ram_low_reg  <= ram_low_reg;
            endcase
        end
    end

    always_comb
    begin
        gpage_off  = address - GPAGE_BASE;
        spr_off    = address - SPR_BASE;
        gpal_off   = address - GPAL_BASE;
        off        = gpal_off[OFF_W-1:0];
        case (access_size)
            SZ_BYTE: dmask = {24'h0, write_data[7:0]};
            SZ_WORD: dmask = {16'h0, write_data[15:0]};
            default: dmask = write_data;
        endcase
        dec_tgt    = T_RAM;
        dec_fc     = FC_NONE;
        dec_idx    = address;
        dec_data   = 32'h0;
        dec_pal_rd = 1'b0;
        dec_pal_wr = 1'b0;
        if (access_size == SZ_BAD)
        begin
            dec_tgt = T_FAULT;
            dec_fc  = FC_SIZE;
        end
        else if (address >= ram_low_reg && address < ram_high_reg)
        begin
            dec_data = func ? dmask : 32'h0;
        end
        else if ((address >= GPAL_END && address < TPAL_END) || address == PRIO_ADDR
                 || (address >= PCG_BASE && address < PCG_END))
        begin
            dec_tgt = T_IGN;
        end
        else if (func && address >= GPAGE_BASE && address < GPAGE_END)
        begin
            if (access_size != SZ_WORD)
            begin
                dec_tgt = T_FAULT;
                dec_fc  = FC_SIZE;
            end
            else
            begin
                dec_tgt  = T_GFX;
                dec_idx  = {1'b0, gpage_off[23:1]};
                dec_data = {16'h0, write_data[15:0]};
            end
        end
        else if (func && address >= SPR_BASE && address < SPR_END)
        begin
            if (access_size != SZ_WORD)
            begin
                dec_tgt = T_FAULT;
                dec_fc  = FC_SIZE;
            end
            else
            begin
                dec_tgt  = T_SPR;
                dec_idx  = {1'b0, spr_off[23:1]};
                dec_data = {16'h0, write_data[15:0]};
            end
        end
        else if (address >= GPAL_BASE && address < GPAL_END)
        begin
            if (func && (access_size != SZ_WORD || off[0]))
            begin
                dec_tgt = T_FAULT;
                dec_fc  = FC_SIZE;
            end
            else
            begin
                dec_tgt = T_PAL;
                dec_idx = {15'h0, off[OFF_W-1:1]};
                if (func)
                begin
                    dec_data   = {16'h0, write_data[15:0]};
                    dec_pal_wr = ({22'h0, off} < 32'(PAL_BYTES));
                end
                else
                begin
                    dec_pal_rd = 1'b1;
                end
            end
        end
        else if (address >= IO_BASE)
        begin
            dec_tgt = T_FAULT;
            dec_fc  = FC_IO;
        end
        else if (!supervisor || address >= ram_high_reg)
        begin
            dec_tgt = T_FAULT;
            dec_fc  = FC_INVAL;
        end
        else
        begin
            dec_data = func ? dmask : 32'h0;
        end
    end

    assign wr_row  = off[ROW_W+1:2];
    assign wr_widx = off[WIDX_W:1];

    for (genvar k = 0; k < 4; k++)
    begin : g_bank
        logic [7:0]       mem [PAL_ROWS];
        logic [1:0]       kk;
        logic [ROW_W-1:0] rd_row;

        assign kk = 2'(k);
        assign bank_we[k] = in_fire && dec_pal_wr && (kk[1] == off[1]);
        assign rd_byte_addr[k] = off + {8'h0, 2'(kk - off[1:0])};
        assign rd_inr[k] = ({22'h0, rd_byte_addr[k]} < 32'(PAL_BYTES));
        assign rd_row = rd_byte_addr[k][ROW_W+1:2];

        always_ff @(posedge clk)
        begin
            if (bank_we[k])
            begin
                mem[wr_row] <= kk[0] ? write_data[7:0] : write_data[15:8];
            end
            if (in_fire)
            begin
                s1_mem_reg[k] <= mem[rd_row];
                s1_vld_reg[k] <= vld_reg[rd_byte_addr[k][WIDX_W:1]];
                s1_rst_reg[k] <= pal_reset_byte(rd_byte_addr[k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (in_fire && dec_pal_wr)
        begin
            vld_reg[wr_widx] <= 1'b1;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (s1_move)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_tgt_reg    <= dec_tgt;
            s1_fc_reg     <= dec_fc;
            s1_idx_reg    <= dec_idx;
            s1_data_reg   <= dec_data;
            s1_pal_rd_reg <= dec_pal_rd;
            s1_sz_reg     <= access_size;
            s1_off_lo_reg <= off[1:0];
            s1_inr_reg    <= rd_inr;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (!s1_inr_reg[k])
            begin
                bank_byte[k] = 8'h0;
            end
            else if (s1_vld_reg[k])
            begin
                bank_byte[k] = s1_mem_reg[k];
            end
            else
            begin
                bank_byte[k] = s1_rst_reg[k];
            end
        end
        for (int i = 0; i < 4; i++)
        begin
            pos_byte[i] = bank_byte[2'(s1_off_lo_reg + 2'(i))];
        end
        case (s1_sz_reg)
            SZ_BYTE: rd_word = {24'h0, pos_byte[0]};
            SZ_WORD: rd_word = {16'h0, pos_byte[0], pos_byte[1]};
            default: rd_word = {pos_byte[0], pos_byte[1], pos_byte[2], pos_byte[3]};
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_valid_reg)
        begin
            out_tgt_reg  <= s1_tgt_reg;
            out_fc_reg   <= s1_fc_reg;
            out_idx_reg  <= s1_idx_reg;
            out_data_reg <= s1_pal_rd_reg ? rd_word : s1_data_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign target     = out_tgt_reg;
    assign fault_code = out_fc_reg;
    assign index      = out_idx_reg;
    assign data       = out_data_reg;

endmodule

### sv/bad_checker.sv
// Port-level checker for the bus address decoder and its bind to the top level.
module bad_checker
    import bad_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  target,
    input  logic [1:0]  fault_code,
    input  logic [23:0] index,
    input  logic [31:0] data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("Result beat dropped while stalled.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(index) && $stable(data) && $stable(target))
        else $error("Result beat changed while stalled.");

    a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((target == T_FAULT) == (fault_code != FC_NONE)))
        else $error("Fault code does not match the target.");

    a_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (target == T_IGN || target == T_FAULT) |-> data == 32'h0)
        else $error("Ignored or faulting beat carries data.");

    a_event_width: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (target == T_GFX || target == T_SPR) |->
            data[31:16] == 16'h0 && index[23] == 1'b0)
        else $error("Graphic or sprite event is wider than a word.");

endmodule

bind bus_address_decoder_with_palette_top bad_checker u_bad_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .target     (target),
    .fault_code (fault_code),
    .index      (index),
    .data       (data)
);

### tb/sv/tb_bus_address_decoder_with_palette_top.sv
// Self-checking testbench for the bus address decoder with its graphic palette store.
module tb_bus_address_decoder_with_palette_top;
    import bad_pkg::*;

    typedef struct packed {
        logic        wr;
        logic [23:0] addr;
        logic [1:0]  size;
        logic [31:0] wdata;
        logic        sup;
    } access_t;

    typedef struct packed {
        logic [2:0]  tgt;
        logic [1:0]  fc;
        logic [23:0] idx;
        logic [31:0] dat;
    } decode_t;

    typedef struct {
        access_t acc;
        bit      known;
        decode_t res;
    } vector_t;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int STALL_CYCLES   = 120;
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 140;

    localparam logic [15:0] BOOT_COLORS [16] = '{
        16'h0000, 16'h5294, 16'h0020, 16'h003E, 16'h0400, 16'h07C0, 16'h0420, 16'h07FE,
        16'h0800, 16'hF800, 16'h8020, 16'hF83E, 16'h8400, 16'hFFC0, 16'hAD6A, 16'hFFFF
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = CFG_RAM_LOW;
    logic [23:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        func = 1'b0;
    logic [23:0] address = '0;
    logic [1:0]  access_size = SZ_BYTE;
    logic [31:0] write_data = '0;
    logic        supervisor = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  target;
    logic [1:0]  fault_code;
    logic [23:0] index;
    logic [31:0] data;

    logic [15:0] pal_mem [PALETTE_WORDS];
    logic [23:0] win_lo;
    logic [23:0] win_hi;
    decode_t     pending [$];
    vector_t     dir_tab [$];
    int          mismatches = 0;
    int          cycle_count = 0;
    int          stall_cnt = 0;
    bit          tx_steady = 1'b0;
    bit          rx_steady = 1'b0;

    bus_address_decoder_with_palette_top uut (.*);

    always #6 clk = ~clk;

    function automatic logic [7:0] pal_byte(logic [23:0] off);
        logic [15:0] w;
        if (off >= 24'(PAL_BYTES) || off >= 24'h200)
            return 8'h00;
        w = pal_mem[off[WIDX_W:1]];
        return off[0] ? w[7:0] : w[15:8];
    endfunction

    function automatic decode_t decode_access(access_t a);
        decode_t     r;
        logic [31:0] dm;
        logic [23:0] off;
        int          nbytes;
        r.tgt = T_RAM;
        r.fc  = FC_NONE;
        r.idx = a.addr;
        r.dat = 32'h0;
        dm = (a.size == SZ_BYTE) ? {24'h0, a.wdata[7:0]} :
             (a.size == SZ_WORD) ? {16'h0, a.wdata[15:0]} : a.wdata;
        off = a.addr - GPAL_BASE;
        if (a.size == SZ_BAD) begin
            r.tgt = T_FAULT;
            r.fc  = FC_SIZE;
        end else if (a.addr >= win_lo && a.addr < win_hi) begin
            r.dat = a.wr ? dm : 32'h0;
        end else if ((a.addr >= GPAL_END && a.addr < TPAL_END) || a.addr == PRIO_ADDR ||
                     (a.addr >= PCG_BASE && a.addr < PCG_END)) begin
            r.tgt = T_IGN;
        end else if (a.wr && ((a.addr >= GPAGE_BASE && a.addr < GPAGE_END) ||
                              (a.addr >= SPR_BASE && a.addr < SPR_END))) begin
            if (a.size != SZ_WORD) begin
                r.tgt = T_FAULT;
                r.fc  = FC_SIZE;
            end else if (a.addr < GPAGE_END) begin
                r.tgt = T_GFX;
                r.idx = (a.addr - GPAGE_BASE) >> 1;
                r.dat = {16'h0, a.wdata[15:0]};
            end else begin
                r.tgt = T_SPR;
                r.idx = (a.addr - SPR_BASE) >> 1;
                r.dat = {16'h0, a.wdata[15:0]};
            end
        end else if (a.addr >= GPAL_BASE && a.addr < GPAL_END) begin
            if (a.wr && (a.size != SZ_WORD || off[0])) begin
                r.tgt = T_FAULT;
                r.fc  = FC_SIZE;
            end else begin
                r.tgt = T_PAL;
                r.idx = off >> 1;
                if (a.wr) begin
                    if (r.idx < PALETTE_WORDS)
                        pal_mem[r.idx[WIDX_W-1:0]] = a.wdata[15:0];
                    r.dat = {16'h0, a.wdata[15:0]};
                end else begin
                    nbytes = (a.size == SZ_BYTE) ? 1 : (a.size == SZ_WORD) ? 2 : 4;
                    for (int i = 0; i < nbytes; i++)
                        r.dat = {r.dat[23:0], pal_byte(off + 24'(i))};
                end
            end
        end else if (a.addr >= IO_BASE) begin
            r.tgt = T_FAULT;
            r.fc  = FC_IO;
        end else if (!a.sup || a.addr >= win_hi) begin
            r.tgt = T_FAULT;
            r.fc  = FC_INVAL;
        end else begin
            r.dat = a.wr ? dm : 32'h0;
        end
        return r;
    endfunction

    function automatic access_t random_access();
        access_t     a;
        int          pick;
        logic [23:0] base;
        a.wr    = 1'($urandom_range(0, 1));
        a.size  = ($urandom_range(0, 19) == 0) ? SZ_BAD : 2'($urandom_range(0, 2));
        a.wdata = $urandom;
        a.sup   = ($urandom_range(0, 3) != 0);
        pick    = $urandom_range(0, 99);
        if (pick < 32) begin
            a.addr = GPAL_BASE + 24'($urandom_range(0, 511));
            if (a.wr && $urandom_range(0, 4) != 0) begin
                a.size    = SZ_WORD;
                a.addr[0] = 1'b0;
            end
        end else if (pick < 42) begin
            a.addr = GPAGE_BASE + 24'($urandom_range(0, 24'h7FFFF));
            if ($urandom_range(0, 3) != 0) begin
                a.wr   = 1'b1;
                a.size = SZ_WORD;
            end
        end else if (pick < 50) begin
            a.addr = SPR_BASE + 24'($urandom_range(0, 24'h3FF));
            if ($urandom_range(0, 3) != 0) begin
                a.wr   = 1'b1;
                a.size = SZ_WORD;
            end
        end else if (pick < 56) begin
            case ($urandom_range(0, 2))
                0:       a.addr = GPAL_END + 24'($urandom_range(0, 24'h1FF));
                1:       a.addr = PRIO_ADDR;
                default: a.addr = PCG_BASE + 24'($urandom_range(0, 24'h3FFF));
            endcase
        end else if (pick < 70) begin
            case ($urandom_range(0, 12))
                0:       base = GPAL_BASE;
                1:       base = GPAL_END;
                2:       base = TPAL_END;
                3:       base = PRIO_ADDR;
                4:       base = PCG_BASE;
                5:       base = PCG_END;
                6:       base = GPAGE_BASE;
                7:       base = GPAGE_END;
                8:       base = SPR_BASE;
                9:       base = SPR_END;
                10:      base = IO_BASE;
                11:      base = win_lo;
                default: base = win_hi;
            endcase
            a.addr = base + 24'($urandom_range(0, 3)) - 24'd2;
        end else begin
            a.addr = 24'($urandom);
        end
        return a;
    endfunction

    function automatic vector_t acc_known(logic wr, logic [23:0] a, logic [1:0] sz,
                                          logic [31:0] d, logic sup, logic [2:0] t,
                                          logic [1:0] fc, logic [23:0] idx, logic [31:0] dat);
        vector_t v;
        v.acc   = {wr, a, sz, d, sup};
        v.known = 1'b1;
        v.res   = {t, fc, idx, dat};
        return v;
    endfunction

    function automatic vector_t acc_only(logic wr, logic [23:0] a, logic [1:0] sz,
                                         logic [31:0] d, logic sup);
        vector_t v;
        v.acc   = {wr, a, sz, d, sup};
        v.known = 1'b0;
        v.res   = '0;
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic drive_access(vector_t v);
        decode_t r;
        in_valid    <= 1'b1;
        func        <= v.acc.wr;
        address     <= v.acc.addr;
        access_size <= v.acc.size;
        write_data  <= v.acc.wdata;
        supervisor  <= v.acc.sup;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        r = decode_access(v.acc);
        pending.push_back(v.known ? v.res : r);
        if (!tx_steady && $urandom_range(0, 99) < 14) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_bounds(logic [23:0] lo, logic [23:0] hi);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_RAM_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        win_lo = lo;
        cfg_index <= CFG_RAM_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        win_hi = hi;
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk) begin
        if (stall_cnt > 0) begin
            out_ready <= 1'b0;
            stall_cnt <= stall_cnt - 1;
        end else begin
            out_ready <= rx_steady || ($urandom_range(0, 99) >= 14);
        end
    end

    always @(posedge clk) begin : check_results
        decode_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending.size() == 0) begin
                report_mismatch("unexpected beat at index", {8'h0, index}, 32'h0);
            end else begin
                want = pending.pop_front();
                if (target !== want.tgt)
                    report_mismatch("target", 32'(target), 32'(want.tgt));
                if (fault_code !== want.fc)
                    report_mismatch("fault_code", 32'(fault_code), 32'(want.fc));
                if (index !== want.idx)
                    report_mismatch("index", 32'(index), 32'(want.idx));
                if (data !== want.dat)
                    report_mismatch("data", data, want.dat);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        logic [23:0] lo;
        logic [23:0] hi;
        int          first_window_row;
        vector_t     v;
        for (int i = 0; i < PALETTE_WORDS; i++)
            pal_mem[i] = (i < 16) ? BOOT_COLORS[i] : 16'h0000;
        win_lo = RAM_LOW_RESET;
        win_hi = RAM_HIGH_RESET;

        // The palette rows rely on the fixed colors loaded at reset.
        dir_tab.push_back(acc_known(1'b0, GPAL_BASE + 24'h002, SZ_WORD, 32'h0, 1'b1,
                                    T_PAL, FC_NONE, 24'd1, 32'h00005294));
        dir_tab.push_back(acc_known(1'b0, GPAL_BASE + 24'h01E, SZ_LONG, 32'h0, 1'b0,
                                    T_PAL, FC_NONE, 24'd15, 32'hFFFF0000));
        dir_tab.push_back(acc_known(1'b0, GPAL_BASE + 24'h01D, SZ_BYTE, 32'h0, 1'b1,
                                    T_PAL, FC_NONE, 24'd14, 32'h0000006A));
        dir_tab.push_back(acc_known(1'b1, GPAL_BASE + 24'h1FE, SZ_WORD, 32'h1234ABCD, 1'b0,
                                    T_PAL, FC_NONE, 24'd255, 32'h0000ABCD));
        dir_tab.push_back(acc_known(1'b0, GPAL_BASE + 24'h1FF, SZ_LONG, 32'hFFFFFFFF, 1'b1,
                                    T_PAL, FC_NONE, 24'd255, 32'hCD000000));
        dir_tab.push_back(acc_known(1'b1, GPAL_BASE + 24'h1FE, SZ_BYTE, 32'hFFFFFFFF, 1'b1,
                                    T_FAULT, FC_SIZE, GPAL_BASE + 24'h1FE, 32'h0));
        dir_tab.push_back(acc_known(1'b1, GPAL_BASE + 24'h1FD, SZ_WORD, 32'hFFFFFFFF, 1'b1,
                                    T_FAULT, FC_SIZE, GPAL_BASE + 24'h1FD, 32'h0));
        dir_tab.push_back(acc_known(1'b1, GPAL_BASE, SZ_LONG, 32'hFFFFFFFF, 1'b0,
                                    T_FAULT, FC_SIZE, GPAL_BASE, 32'h0));
        dir_tab.push_back(acc_known(1'b0, GPAL_BASE + 24'h1FE, SZ_WORD, 32'h0, 1'b1,
                                    T_PAL, FC_NONE, 24'd255, 32'h0000ABCD));
        dir_tab.push_back(acc_known(1'b0, 24'h000000, SZ_BAD, 32'hFFFFFFFF, 1'b1,
                                    T_FAULT, FC_SIZE, 24'h000000, 32'h0));
        dir_tab.push_back(acc_known(1'b1, 24'h000000, SZ_LONG, 32'hFFFFFFFF, 1'b1,
                                    T_RAM, FC_NONE, 24'h000000, 32'hFFFFFFFF));
        dir_tab.push_back(acc_known(1'b1, 24'hBFFFFF, SZ_BYTE, 32'hDEADBEEF, 1'b0,
                                    T_RAM, FC_NONE, 24'hBFFFFF, 32'h000000EF));
        dir_tab.push_back(acc_known(1'b0, 24'h5A5A5A, SZ_WORD, 32'hDEADBEEF, 1'b0,
                                    T_RAM, FC_NONE, 24'h5A5A5A, 32'h0));
        dir_tab.push_back(acc_known(1'b1, GPAL_END, SZ_WORD, 32'h55AA55AA, 1'b1,
                                    T_IGN, FC_NONE, GPAL_END, 32'h0));
        dir_tab.push_back(acc_known(1'b0, PRIO_ADDR, SZ_BYTE, 32'h0, 1'b0,
                                    T_IGN, FC_NONE, PRIO_ADDR, 32'h0));
        dir_tab.push_back(acc_known(1'b1, GPAGE_BASE + 24'd1, SZ_WORD, 32'h0000FFFF, 1'b0,
                                    T_GFX, FC_NONE, 24'h000000, 32'h0000FFFF));
        dir_tab.push_back(acc_known(1'b1, GPAGE_END - 24'd1, SZ_WORD, 32'h55AA1234, 1'b1,
                                    T_GFX, FC_NONE, 24'h03FFFF, 32'h00001234));
        dir_tab.push_back(acc_known(1'b1, SPR_END - 24'd2, SZ_WORD, 32'h80007FFF, 1'b1,
                                    T_SPR, FC_NONE, 24'h0001FF, 32'h00007FFF));
        dir_tab.push_back(acc_known(1'b1, SPR_BASE, SZ_LONG, 32'h12345678, 1'b1,
                                    T_FAULT, FC_SIZE, SPR_BASE, 32'h0));
        dir_tab.push_back(acc_known(1'b0, GPAGE_BASE, SZ_WORD, 32'h0, 1'b1,
                                    T_FAULT, FC_IO, GPAGE_BASE, 32'h0));
        dir_tab.push_back(acc_known(1'b0, 24'hFFFFFF, SZ_BYTE, 32'h0, 1'b1,
                                    T_FAULT, FC_IO, 24'hFFFFFF, 32'h0));
        dir_tab.push_back(acc_only(1'b1, GPAL_BASE + 24'h010, SZ_WORD, $urandom, 1'b0));
        dir_tab.push_back(acc_only(1'b0, GPAL_BASE + 24'h00F, SZ_LONG, $urandom, 1'b1));
        first_window_row = dir_tab.size();
        // These rows run with the window moved to [0x100000, 0x800000).
        dir_tab.push_back(acc_known(1'b0, 24'h000010, SZ_BYTE, 32'h0, 1'b0,
                                    T_FAULT, FC_INVAL, 24'h000010, 32'h0));
        dir_tab.push_back(acc_known(1'b1, 24'h0FFFFF, SZ_WORD, 32'h12345678, 1'b1,
                                    T_RAM, FC_NONE, 24'h0FFFFF, 32'h00005678));
        dir_tab.push_back(acc_known(1'b0, 24'h800000, SZ_LONG, 32'h0, 1'b1,
                                    T_FAULT, FC_INVAL, 24'h800000, 32'h0));
        dir_tab.push_back(acc_known(1'b1, 24'h100000, SZ_LONG, 32'h12345678, 1'b1,
                                    T_RAM, FC_NONE, 24'h100000, 32'h12345678));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < dir_tab.size(); i++) begin
            if (i == first_window_row) begin
                wait_for_results();
                write_bounds(24'h100000, 24'h800000);
            end
            drive_access(dir_tab[i]);
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_for_results();
            case (p)
                0: begin lo = RAM_LOW_RESET; hi = RAM_HIGH_RESET; end
                1: begin lo = 24'hFFFFFF;    hi = 24'h000000;     end
                2: begin lo = 24'h000000;    hi = 24'hFFFFFF;     end
                3: begin lo = 24'h100000;    hi = 24'h800000;     end
                4: begin lo = 24'h000000;    hi = 24'h000000;     end
                5: begin lo = 24'h400000;    hi = 24'hD80000;     end
                default:
                begin
                    lo = 24'($urandom_range(0, 24'hBFFFFF));
                    hi = 24'($urandom);
                end
            endcase
            write_bounds(lo, hi);
            // The first phase opens with a long output stall so the pipeline backs up.
            if (p == 0)
                stall_cnt <= STALL_CYCLES;
            tx_steady = (p == 0) || (p == 3);
            rx_steady = (p == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                v.acc   = random_access();
                v.known = 1'b0;
                v.res   = '0;
                drive_access(v);
            end
        end

        tx_steady = 1'b0;
        rx_steady = 1'b0;
        wait_for_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
